/* sv/gps_info_field_parser_macros.svh */
// ---------------------------------------------------------------------------
// GPS info field parser assertion macros
// Concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef GPS_INFO_FIELD_PARSER_MACROS_SVH
`define GPS_INFO_FIELD_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// plain property check
`define GIFP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// overlapping implication check
`define GIFP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define GIFP_ASSERT(name, prop, msg)
`define GIFP_ASSERT_IMPL(name, ante, cons, msg)

`endif

`endif

/* sv/gifp_pkg.sv */
// ---------------------------------------------------------------------------
// GPS info field parser package
// Shared types, character codes, register map and the decimal accumulator.
// ---------------------------------------------------------------------------
package gifp_pkg;

  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;

  localparam logic [15:0] SnrLowReset  = 16'd350;
  localparam logic [15:0] SnrHighReset = 16'd1000;
  localparam logic [7:0]  MinSatReset  = 8'd3;

  typedef enum logic [1:0] {
    RegSnrLow  = 2'd0,
    RegSnrHigh = 2'd1,
    RegMinSat  = 2'd2
  } cfg_reg_e;

  // one position report byte handed to the position parser
  typedef struct packed {
    logic       strobe;
    logic [7:0] data;
    logic       last;
  } pos_byte_t;

  // stored position report values
  typedef struct packed {
    logic [15:0] snr;
    logic [7:0]  lon_whole;
    logic [31:0] lon_fraction;
    logic [7:0]  lat_whole;
    logic [31:0] lat_fraction;
    logic [15:0] speed;
    logic        fix_valid;
  } pos_info_t;

  // result item, MSB first so that snr lands in the low bits
  typedef struct packed {
    logic [5:0]  pad;
    logic        position_locked;
    logic        fix_valid;
    logic [7:0]  satellites;
    logic [15:0] speed;
    logic [31:0] lat_fraction;
    logic [7:0]  lat_whole;
    logic [31:0] lon_fraction;
    logic [7:0]  lon_whole;
    logic [15:0] snr;
  } result_t;

  // acc*10 + (byte - '0'), modulo 2^32, applied to any byte
  function automatic logic [31:0] acc_push(input logic [31:0] acc, input logic [7:0] b);
    acc_push = (acc << 3) + (acc << 1) + {24'd0, b} - {24'd0, CharZero};
  endfunction

endpackage

/* sv/gifp_pos_parser.sv */
// ---------------------------------------------------------------------------
// GPS info field parser, position report section
// Walks the comma/dot separated fields and keeps the stored position values.
// ---------------------------------------------------------------------------
module gifp_pos_parser import gifp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pos_byte_t pbyte_i,
  output pos_info_t info_o
);

  logic [2:0]  comma_q, comma_d;
  logic [1:0]  dot_q, dot_d;
  logic [31:0] field_acc_q, field_acc_d;
  logic [7:0]  digits_q, digits_d;
  logic [31:0] tail_q, tail_d;
  pos_info_t   info_q, info_d;

  logic is_comma, is_dot;

  assign is_comma = (pbyte_i.data == CharComma);
  assign is_dot   = (pbyte_i.data == CharDot);

  always_comb begin
    comma_d     = comma_q;
    dot_d       = dot_q;
    field_acc_d = field_acc_q;
    digits_d    = digits_q;
    tail_d      = tail_q;
    info_d      = info_q;
    if (pbyte_i.strobe) begin
      // speed tail takes every byte once the fourth field is closed
      if (comma_q >= 3'd4) begin
        tail_d = acc_push(tail_q, pbyte_i.data);
      end
      if (is_comma) begin
        case (comma_q)
          3'd1: info_d.snr = field_acc_q[15:0];
          3'd2: info_d.lon_fraction = field_acc_q;
          3'd3: begin
            info_d.lat_fraction = field_acc_q;
            tail_d = '0;
          end
          default: ;
        endcase
        if (comma_q != 3'd7) begin
          comma_d = comma_q + 3'd1;
        end
        field_acc_d = '0;
        digits_d    = '0;
      end else if (is_dot) begin
        case (dot_q)
          2'd0: begin
            if (digits_q >= 8'd2) begin
              info_d.lon_whole = field_acc_q[7:0];
              info_d.fix_valid = 1'b1;
            end else begin
              info_d.fix_valid = 1'b0;
            end
          end
          2'd1: begin
            if (digits_q >= 8'd2) begin
              info_d.lat_whole = field_acc_q[7:0];
            end
          end
          default: ;
        endcase
        if (dot_q < 2'd2) begin
          dot_d = dot_q + 2'd1;
        end
        field_acc_d = '0;
        digits_d    = '0;
      end else begin
        field_acc_d = acc_push(field_acc_q, pbyte_i.data);
        if (digits_q != 8'hFF) begin
          digits_d = digits_q + 8'd1;
        end
      end
      if (pbyte_i.last) begin
        if (comma_d >= 3'd4) begin
          info_d.speed = tail_d[15:0];
        end
        comma_d     = '0;
        dot_d       = '0;
        field_acc_d = '0;
        digits_d    = '0;
        tail_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comma_q     <= '0;
      dot_q       <= '0;
      field_acc_q <= '0;
      digits_q    <= '0;
      tail_q      <= '0;
      info_q      <= '0;
    end else begin
      comma_q     <= comma_d;
      dot_q       <= dot_d;
      field_acc_q <= field_acc_d;
      digits_q    <= digits_d;
      tail_q      <= tail_d;
      info_q      <= info_d;
    end
  end

  // values after the current byte, so the report end sees its own last byte
  assign info_o = info_d;

endmodule

/* sv/gps_info_field_parser.sv */
// ---------------------------------------------------------------------------
// GPS info field parser
// Parses modem position and satellite report payloads into stored values.
// ---------------------------------------------------------------------------
// Takes one payload byte per clock (tuser selects position or satellite
// report, tlast marks the final byte). Each accepted last byte yields one
// result item on the master side, registered, in the cycle after the byte is
// taken. The input stalls only while a result is held and the sink is not
// ready; otherwise the rate is one byte per cycle, as the decimal accumulators
// take each accepted byte. SNR window and satellite minimum are set over
// the APB port (0x0 snr_low, 0x4 snr_high, 0x8 min_satellites).
`include "gps_info_field_parser_macros.svh"

module gps_info_field_parser import gifp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // stream in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // last_byte
  input  logic         s_axis_tuser,   // [0] action
  // stream out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] snr, [23:16] lon_whole, [55:24] lon_fraction, [63:56] lat_whole,
  // [95:64] lat_fraction, [111:96] speed, [119:112] satellites,
  // [120] fix_valid, [121] position_locked, [127:122] zero
  output logic [127:0] m_axis_tdata,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [15:0] snr_low_q, snr_high_q;
  logic [7:0]  min_sat_q;
  logic        cfg_we;
  cfg_reg_e    cfg_sel;

  logic        in_accept;
  pos_byte_t   pos_byte;
  pos_info_t   pos_info;

  logic [31:0] count_acc_q, count_acc_d;
  logic        count_comma_seen_q, count_comma_seen_d;
  logic [7:0]  sat_q, sat_d;
  logic        lock_q, lock_d;
  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snr_low_q  <= SnrLowReset;
      snr_high_q <= SnrHighReset;
      min_sat_q  <= MinSatReset;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        RegSnrLow:  snr_low_q  <= pwdata[15:0];
        RegSnrHigh: snr_high_q <= pwdata[15:0];
        RegMinSat:  min_sat_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      RegSnrLow:  prdata = {16'd0, snr_low_q};
      RegSnrHigh: prdata = {16'd0, snr_high_q};
      RegMinSat:  prdata = {24'd0, min_sat_q};
      default:    prdata = '0;
    endcase
  end

  // ---------------- input ----------------
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign pos_byte.strobe = in_accept && !s_axis_tuser;
  assign pos_byte.data   = s_axis_tdata;
  assign pos_byte.last   = s_axis_tlast;

  gifp_pos_parser u_pos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pbyte_i (pos_byte),
    .info_o  (pos_info)
  );

  // ---------------- satellite count report ----------------
  always_comb begin
    count_acc_d        = count_acc_q;
    count_comma_seen_d = count_comma_seen_q;
    sat_d              = sat_q;
    if (in_accept && s_axis_tuser) begin
      if (s_axis_tdata == CharComma) begin
        count_acc_d        = '0;
        count_comma_seen_d = 1'b1;
      end else begin
        count_acc_d = acc_push(count_acc_q, s_axis_tdata);
      end
      if (s_axis_tlast) begin
        if (count_comma_seen_d) begin
          sat_d = count_acc_d[7:0];
        end
        count_acc_d        = '0;
        count_comma_seen_d = 1'b0;
      end
    end
  end

  // ---------------- lock and result ----------------
  always_comb begin
    lock_d = lock_q;
    if (in_accept && s_axis_tlast && pos_info.fix_valid &&
        (pos_info.snr >= snr_low_q) && (pos_info.snr <= snr_high_q) &&
        (sat_d >= min_sat_q)) begin
      lock_d = 1'b1;
    end
  end

  always_comb begin
    res_d                 = '0;
    res_d.snr             = pos_info.snr;
    res_d.lon_whole       = pos_info.lon_whole;
    res_d.lon_fraction    = pos_info.lon_fraction;
    res_d.lat_whole       = pos_info.lat_whole;
    res_d.lat_fraction    = pos_info.lat_fraction;
    res_d.speed           = pos_info.speed;
    res_d.satellites      = sat_d;
    res_d.fix_valid       = pos_info.fix_valid;
    res_d.position_locked = lock_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept && s_axis_tlast) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_acc_q        <= '0;
      count_comma_seen_q <= 1'b0;
      sat_q              <= '0;
      lock_q             <= 1'b0;
      out_valid_q        <= 1'b0;
    end else begin
      count_acc_q        <= count_acc_d;
      count_comma_seen_q <= count_comma_seen_d;
      sat_q              <= sat_d;
      lock_q             <= lock_d;
      out_valid_q        <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && s_axis_tlast) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

  // ---------------- checks ----------------
  `GIFP_ASSERT(a_lock_sticky, lock_q |=> lock_q, "lock flag dropped")
  `GIFP_ASSERT_IMPL(a_out_from_last, $rose(out_valid_q), $past(in_accept && s_axis_tlast),
                    "result appeared without a last item")
  `GIFP_ASSERT_IMPL(a_lock_with_result, $rose(lock_q),
                    out_valid_q && res_q.fix_valid && res_q.position_locked,
                    "lock set without a matching result")
  `GIFP_ASSERT(a_count_cleared, (in_accept && s_axis_tuser && s_axis_tlast) |=>
               (count_acc_q == 32'd0 && !count_comma_seen_q),
               "satellite parse state not cleared at report end")

endmodule
